/* sv/lobfs_pkg.sv */
// lobfs_pkg: shared types, operation and result codes for the order book core
// used by lobfs_out_stage and limit_order_book_fill_sim_core
package lobfs_pkg;

    localparam int SIDE_DEPTH_DEF = 32;

    // operation codes on the input tuser
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TRADE  = 2'd2;

    // result kinds on the output tuser
    localparam logic [2:0] KIND_ACK       = 3'd0;
    localparam logic [2:0] KIND_FILL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_DUPLICATE = 3'd4;
    localparam logic [2:0] KIND_SIDE_FULL = 3'd5;

    // one resting order as stored in the book memory
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] price;
        logic [31:0] qty;
    } entry_t;

    // one result beat
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic [31:0] qty;
        logic [31:0] price;
        logic        full;
        logic        last;
    } res_t;

endpackage

/* sv/lobfs_out_stage.sv */
// lobfs_out_stage: registered result beat between the book sequencer and the master port
// depends on lobfs_pkg for the result beat type
module lobfs_out_stage
    import lobfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  res_t        push_beat,
    output logic        ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // result_id, fill_quantity, fill_price, order_done
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast
);

    logic valid_reg;
    res_t beat_reg;

    assign ready = !valid_reg || m_tready;

    // hold a beat until the master side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && push) begin
            beat_reg <= push_beat;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, beat_reg.full, beat_reg.price, beat_reg.qty, beat_reg.id};
    assign m_tuser  = beat_reg.kind;
    assign m_tlast  = beat_reg.last;

endmodule

/* sv/limit_order_book_fill_sim_core.sv */
// limit order book core, one item at a time: s_tready is high only in the idle cycle between items
// a sweep over one side reads its orders in slot order and ends once the last read is checked
// add or cancel miss: both sides are swept before the first beat, also on an empty book
// cancel hit stops at the order, then shifts the rest of that side up in one more sweep
// trade: each fill takes a sweep, a fill step and an emit, then one compaction sweep per touched side
// sync active-low reset empties both sides via their fill counts; needs lobfs_pkg, lobfs_out_stage
module limit_order_book_fill_sim_core
    import lobfs_pkg::*;
#(
    parameter int SIDE_DEPTH = SIDE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // req_id, is_sell, price, quantity
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // result_id, fill_quantity, fill_price, order_done
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast
);

    localparam int IW = $clog2(SIDE_DEPTH);
    localparam int CW = $clog2(SIDE_DEPTH + 1);
    localparam int AW = IW + 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_SHIFT   = 3'd2;
    localparam logic [2:0] ST_FSCAN   = 3'd3;
    localparam logic [2:0] ST_FILL    = 3'd4;
    localparam logic [2:0] ST_COMPACT = 3'd5;
    localparam logic [2:0] ST_EMIT    = 3'd6;
    localparam logic [2:0] ST_FIN     = 3'd7;

    // fill priority on one side: better price, then older slot
    function automatic logic goes_first(logic side, logic [31:0] pa, logic [IW-1:0] ia,
                                        logic [31:0] pb, logic [IW-1:0] ib);
        logic r;
        if (pa != pb) begin
            r = side ? (pa < pb) : (pa > pb);
        end else begin
            r = ia < ib;
        end
        return r;
    endfunction

    logic [2:0]    state_reg, state_next, ret_reg, ret_next;
    logic [1:0]    op_reg, op_next;
    logic [15:0]   id_reg, id_next;
    logic          sell_reg, sell_next;
    logic [31:0]   px_reg, px_next, rem_reg, rem_next;
    logic          sd_reg, sd_next;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] cnt_next [2];
    logic [CW-1:0] iss_reg, iss_next, w_reg, w_next;
    logic          qv_reg, qv_next;
    logic [IW-1:0] qi_reg, qi_next;
    logic          best_v_reg, best_v_next;
    entry_t        best_reg, best_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic          hl_reg, hl_next, last_full_reg, last_full_next;
    logic [31:0]   last_px_reg, last_px_next;
    logic [IW-1:0] last_idx_reg, last_idx_next;
    res_t          res_reg, res_next, hold_reg, hold_next;
    logic          hold_v_reg, hold_v_next;

    // book memory, address is {side, slot}
    entry_t        mem [2**AW];
    entry_t        mem_q;
    logic          we, re;
    logic [AW-1:0] wa, ra;
    entry_t        wd;

    logic          push, out_ready;
    res_t          push_beat;

    logic          scanning, issue, scan_done, qual, hit;
    logic [CW-1:0] cnt_cur;
    logic [31:0]   fill_q, new_q;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            mem_q <= mem[ra];
        end
    end

    // scan engine shared by every sweep over one side
    always_comb begin
        scanning  = (state_reg == ST_DUP) || (state_reg == ST_SHIFT) ||
                    (state_reg == ST_FSCAN) || (state_reg == ST_COMPACT);
        cnt_cur   = cnt_reg[sd_reg];
        issue     = scanning && (iss_reg < cnt_cur);
        scan_done = scanning && !issue && !qv_reg;
        re        = issue;
        ra        = {sd_reg, iss_reg[IW-1:0]};
        qual      = sd_reg ? (mem_q.price < px_reg) : (mem_q.price > px_reg);
        hit       = qual && (goes_first(sd_reg, mem_q.price, qi_reg, last_px_reg, last_idx_reg)
                    || ((qi_reg == last_idx_reg) && last_full_reg));
        fill_q    = (rem_reg < best_reg.qty) ? rem_reg : best_reg.qty;
        new_q     = best_reg.qty - fill_q;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        sell_next      = sell_reg;
        px_next        = px_reg;
        rem_next       = rem_reg;
        sd_next        = sd_reg;
        cnt_next       = cnt_reg;
        iss_next       = issue ? iss_reg + CW'(1) : iss_reg;
        qv_next        = issue;
        qi_next        = issue ? iss_reg[IW-1:0] : qi_reg;
        w_next         = w_reg;
        best_v_next    = best_v_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        hl_next        = hl_reg;
        last_full_next = last_full_reg;
        last_px_next   = last_px_reg;
        last_idx_next  = last_idx_reg;
        res_next       = res_reg;
        hold_next      = hold_reg;
        hold_v_next    = hold_v_reg;
        s_tready       = 1'b0;
        we             = 1'b0;
        wa             = {sd_reg, w_reg[IW-1:0]};
        wd             = mem_q;
        push           = 1'b0;
        push_beat      = hold_reg;
        res_next.last  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    id_next     = s_tdata[15:0];
                    sell_next   = s_tdata[16];
                    px_next     = s_tdata[48:17];
                    rem_next    = s_tdata[80:49];
                    sd_next     = 1'b0;
                    iss_next    = '0;
                    qv_next     = 1'b0;
                    hl_next     = 1'b0;
                    best_v_next = 1'b0;
                    unique case (s_tuser) inside
                        OP_ADD, OP_CANCEL: state_next = ST_DUP;
                        OP_TRADE:          state_next = ST_FSCAN;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DUP: begin
                res_next.id    = id_reg;
                res_next.qty   = '0;
                res_next.price = '0;
                res_next.full  = 1'b0;
                ret_next       = ST_FIN;
                if (qv_reg && (mem_q.id == id_reg)) begin
                    if (op_reg == OP_ADD) begin
                        res_next.kind = KIND_DUPLICATE;
                        state_next    = ST_EMIT;
                    end else begin
                        iss_next   = CW'(qi_reg) + CW'(1);
                        w_next     = CW'(qi_reg);
                        qv_next    = 1'b0;
                        state_next = ST_SHIFT;
                    end
                end else if (scan_done) begin
                    if (!sd_reg) begin
                        sd_next  = 1'b1;
                        iss_next = '0;
                    end else if (op_reg == OP_ADD) begin
                        state_next = ST_EMIT;
                        if (cnt_reg[sell_reg] == CW'(SIDE_DEPTH)) begin
                            res_next.kind = KIND_SIDE_FULL;
                        end else begin
                            res_next.kind      = KIND_ACK;
                            we                 = 1'b1;
                            wa                 = {sell_reg, cnt_reg[sell_reg][IW-1:0]};
                            wd.id              = id_reg;
                            wd.price           = px_reg;
                            wd.qty             = rem_reg;
                            cnt_next[sell_reg] = cnt_reg[sell_reg] + CW'(1);
                        end
                    end else begin
                        res_next.kind = KIND_NOT_FOUND;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_SHIFT: begin
                // close the gap left by the cancelled order
                if (qv_reg) begin
                    we     = 1'b1;
                    w_next = w_reg + CW'(1);
                end
                if (scan_done) begin
                    cnt_next[sd_reg] = cnt_reg[sd_reg] - CW'(1);
                    res_next.kind    = KIND_CANCELLED;
                    state_next       = ST_EMIT;
                end
            end
            ST_FSCAN: begin
                // pick the best order not yet touched by this trade
                if (qv_reg && qual &&
                    (!hl_reg || goes_first(sd_reg, last_px_reg, last_idx_reg,
                                           mem_q.price, qi_reg)) &&
                    (!best_v_reg || goes_first(sd_reg, mem_q.price, qi_reg,
                                               best_reg.price, best_idx_reg))) begin
                    best_v_next   = 1'b1;
                    best_next     = mem_q;
                    best_idx_next = qi_reg;
                end
                if (scan_done) begin
                    if (best_v_reg && (rem_reg != '0)) begin
                        state_next = ST_FILL;
                    end else if (hl_reg) begin
                        iss_next   = '0;
                        w_next     = '0;
                        state_next = ST_COMPACT;
                    end else if (!sd_reg) begin
                        sd_next     = 1'b1;
                        iss_next    = '0;
                        best_v_next = 1'b0;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FILL: begin
                we             = 1'b1;
                wa             = {sd_reg, best_idx_reg};
                wd.id          = best_reg.id;
                wd.price       = best_reg.price;
                wd.qty         = new_q;
                rem_next       = rem_reg - fill_q;
                hl_next        = 1'b1;
                last_px_next   = best_reg.price;
                last_idx_next  = best_idx_reg;
                last_full_next = (new_q == '0);
                res_next.kind  = KIND_FILL;
                res_next.id    = best_reg.id;
                res_next.qty   = fill_q;
                res_next.price = best_reg.price;
                res_next.full  = (new_q == '0);
                iss_next       = '0;
                qv_next        = 1'b0;
                best_v_next    = 1'b0;
                ret_next       = ST_FSCAN;
                state_next     = ST_EMIT;
            end
            ST_COMPACT: begin
                // drop the orders this trade emptied, keep arrival order
                if (qv_reg && !hit) begin
                    we     = 1'b1;
                    w_next = w_reg + CW'(1);
                end
                if (scan_done) begin
                    cnt_next[sd_reg] = w_reg;
                    if (!sd_reg) begin
                        sd_next     = 1'b1;
                        iss_next    = '0;
                        hl_next     = 1'b0;
                        best_v_next = 1'b0;
                        state_next  = ST_FSCAN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_EMIT: begin
                // release the held beat, keep the new one until the next is known
                if (!hold_v_reg || out_ready) begin
                    push        = hold_v_reg;
                    hold_next   = res_reg;
                    hold_v_next = 1'b1;
                    state_next  = ret_reg;
                end
            end
            ST_FIN: begin
                push_beat.last = 1'b1;
                if (!hold_v_reg) begin
                    state_next = ST_IDLE;
                end else if (out_ready) begin
                    push        = 1'b1;
                    hold_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            qv_reg     <= 1'b0;
            hold_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            qv_reg     <= qv_next;
            hold_v_reg <= hold_v_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        ret_reg       <= ret_next;
        op_reg        <= op_next;
        id_reg        <= id_next;
        sell_reg      <= sell_next;
        px_reg        <= px_next;
        rem_reg       <= rem_next;
        sd_reg        <= sd_next;
        iss_reg       <= iss_next;
        qi_reg        <= qi_next;
        w_reg         <= w_next;
        best_v_reg    <= best_v_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        hl_reg        <= hl_next;
        last_full_reg <= last_full_next;
        last_px_reg   <= last_px_next;
        last_idx_reg  <= last_idx_next;
        res_reg       <= res_next;
        hold_reg      <= hold_next;
    end

    lobfs_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_beat (push_beat),
        .ready     (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
